### src/v3a_pkg.sv
// Package for the three-component vector ALU: opcodes, defaults and the opcode class carried from front to back.
`default_nettype none
package v3a_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FUNC_W         = 3;

    typedef enum logic [FUNC_W-1:0] {
        OP_CROSS = 3'd0,
        OP_SUM   = 3'd1,
        OP_DIFF  = 3'd2,
        OP_SCALE = 3'd3,
        OP_NORM  = 3'd4,
        OP_DOT   = 3'd5,
        OP_LEN   = 3'd6,
        OP_CMP   = 3'd7
    } t_func;

    typedef struct packed {
        logic mul;
        logic root;
        logic div;
    } t_class;

    function automatic t_class classify(input t_func f);
        t_class c;
        c.mul  = (f == OP_CROSS) || (f == OP_SCALE) || (f == OP_DOT);
        c.root = (f == OP_NORM) || (f == OP_LEN);
        c.div  = (f == OP_NORM);
        return c;
    endfunction

endpackage
`default_nettype wire

### src/v3a_fifo.sv
// Small synchronous queue with registered state, used as the front queue and as the result queue.
`default_nettype none
module v3a_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
        end
    end
endmodule
`default_nettype wire

### src/v3a_back.sv
// Back part: pipelined multiply, square root, divide, saturation and result formatting.
`default_nettype none
module v3a_back #(
    parameter int CW = v3a_pkg::COMP_WIDTH_DEF,
    parameter int FB = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire v3a_pkg::t_func       i_func,
    input  wire v3a_pkg::t_class      i_cls,
    input  wire logic signed [CW-1:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_f,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [CW-1:0]      o_rx, o_ry, o_rz, o_rs,
    output logic                      o_eq, o_ov, o_zl
);
    // Intermediate width: products 2*CW, sums of three plus slack.
    localparam int PW = 2*CW + 3;
    localparam int SW = 2*CW + 2;         // sum of squares, unsigned
    localparam int LW = CW + 1;           // square root width
    localparam int NW = CW + FB;          // normalize numerator magnitude
    localparam int QW = NW;               // quotient width
    localparam int RS = LW;               // root steps, one bit each
    localparam int DS = NW;               // divide steps, one bit each
    localparam int NS = 3 + RS + DS + 1;  // stages total

    typedef struct packed {
        logic                 v;
        v3a_pkg::t_func       func;
        logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    } t_ctl;

    typedef logic signed [PW-1:0] t_w;

    logic w_adv;
    assign w_adv = !o_valid || i_ready;
    assign o_ready = w_adv;

    // Stage 1: products
    t_ctl r_c1;
    t_w r_p [9];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.v <= 1'b0;
        end else if (w_adv) begin
            r_c1.v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1.func <= i_func;
            r_c1.ax <= i_ax; r_c1.ay <= i_ay; r_c1.az <= i_az;
            r_c1.bx <= i_bx; r_c1.by <= i_by; r_c1.bz <= i_bz;
            if (i_cls.mul) begin
                if (i_func == v3a_pkg::OP_SCALE) begin
                    r_p[0] <= PW'(i_ax * i_f);
                    r_p[1] <= PW'(i_ay * i_f);
                    r_p[2] <= PW'(i_az * i_f);
                    r_p[3] <= '0; r_p[4] <= '0; r_p[5] <= '0;
                end else if (i_func == v3a_pkg::OP_DOT) begin
                    r_p[0] <= PW'(i_ax * i_bx);
                    r_p[1] <= PW'(i_ay * i_by);
                    r_p[2] <= PW'(i_az * i_bz);
                    r_p[3] <= '0; r_p[4] <= '0; r_p[5] <= '0;
                end else begin
                    r_p[0] <= PW'(i_ay * i_bz); r_p[3] <= PW'(i_by * i_az);
                    r_p[1] <= PW'(i_az * i_bx); r_p[4] <= PW'(i_bz * i_ax);
                    r_p[2] <= PW'(i_ax * i_by); r_p[5] <= PW'(i_bx * i_ay);
                end
            end else begin
                for (int k = 0; k < 6; k++) r_p[k] <= '0;
            end
            r_p[6] <= PW'(i_ax * i_ax);
            r_p[7] <= PW'(i_ay * i_ay);
            r_p[8] <= PW'(i_az * i_az);
        end
    end

    // Stage 2: combine
    t_ctl r_c2;
    t_w r_s [4];
    logic [SW-1:0] r_ss;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.v <= 1'b0;
        end else if (w_adv) begin
            r_c2.v <= r_c1.v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c2.func <= r_c1.func;
            r_c2.ax <= r_c1.ax; r_c2.ay <= r_c1.ay; r_c2.az <= r_c1.az;
            r_c2.bx <= r_c1.bx; r_c2.by <= r_c1.by; r_c2.bz <= r_c1.bz;
            r_s[0] <= r_p[0] - r_p[3];
            r_s[1] <= r_p[1] - r_p[4];
            r_s[2] <= r_p[2] - r_p[5];
            r_s[3] <= r_p[0] + r_p[1] + r_p[2];
            r_ss   <= SW'(r_p[6]) + SW'(r_p[7]) + SW'(r_p[8]);
        end
    end

    // Stage 3: shift and saturate product results, sum/diff, compare
    function automatic logic signed [CW-1:0] sat(input t_w x, output logic ov);
        t_w mx, mn;
        mx = t_w'({1'b0, {(CW-1){1'b1}}});
        mn = -mx - t_w'(1);
        ov = 1'b0;
        if (x > mx) begin
            ov = 1'b1;
            return mx[CW-1:0];
        end else if (x < mn) begin
            ov = 1'b1;
            return mn[CW-1:0];
        end
        return x[CW-1:0];
    endfunction

    typedef struct packed {
        logic                 v;
        v3a_pkg::t_func       func;
        logic signed [CW-1:0] x, y, z, s;
        logic                 eq, ov;
        logic signed [CW-1:0] ax, ay, az;
    } t_res;

    t_res r_c3;
    logic [SW-1:0] r_ss3;
    t_res w_r3;
    always_comb begin
        logic o0, o1, o2, o3;
        t_w sx, sy, sz;
        w_r3 = '0;
        w_r3.v = r_c2.v;
        w_r3.func = r_c2.func;
        w_r3.ax = r_c2.ax; w_r3.ay = r_c2.ay; w_r3.az = r_c2.az;
        o0 = 1'b0; o1 = 1'b0; o2 = 1'b0; o3 = 1'b0;
        sx = '0; sy = '0; sz = '0;
        case (r_c2.func)
            v3a_pkg::OP_CROSS: begin
                w_r3.x = sat(r_s[0] >>> FB, o0);
                w_r3.y = sat(r_s[1] >>> FB, o1);
                w_r3.z = sat(r_s[2] >>> FB, o2);
            end
            v3a_pkg::OP_SCALE: begin
                // second operand products are zero for scale
                w_r3.x = sat(r_s[0] >>> FB, o0);
                w_r3.y = sat(r_s[1] >>> FB, o1);
                w_r3.z = sat(r_s[2] >>> FB, o2);
            end
            v3a_pkg::OP_DOT: begin
                w_r3.s = sat(r_s[3] >>> FB, o3);
            end
            v3a_pkg::OP_SUM, v3a_pkg::OP_DIFF: begin
                if (r_c2.func == v3a_pkg::OP_SUM) begin
                    sx = t_w'(r_c2.ax) + t_w'(r_c2.bx);
                    sy = t_w'(r_c2.ay) + t_w'(r_c2.by);
                    sz = t_w'(r_c2.az) + t_w'(r_c2.bz);
                end else begin
                    sx = t_w'(r_c2.ax) - t_w'(r_c2.bx);
                    sy = t_w'(r_c2.ay) - t_w'(r_c2.by);
                    sz = t_w'(r_c2.az) - t_w'(r_c2.bz);
                end
                w_r3.x = sat(sx, o0);
                w_r3.y = sat(sy, o1);
                w_r3.z = sat(sz, o2);
            end
            v3a_pkg::OP_CMP: begin
                w_r3.eq = (r_c2.ax == r_c2.bx) && (r_c2.ay == r_c2.by)
                          && (r_c2.az == r_c2.bz);
            end
            default: begin
            end
        endcase
        w_r3.ov = o0 | o1 | o2 | o3;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3.v <= 1'b0;
        end else if (w_adv) begin
            r_c3.v <= w_r3.v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c3.func <= w_r3.func;
            r_c3.x <= w_r3.x; r_c3.y <= w_r3.y; r_c3.z <= w_r3.z; r_c3.s <= w_r3.s;
            r_c3.eq <= w_r3.eq; r_c3.ov <= w_r3.ov;
            r_c3.ax <= w_r3.ax; r_c3.ay <= w_r3.ay; r_c3.az <= w_r3.az;
            r_ss3 <= r_ss;
        end
    end

    // Square root pipeline: digit recurrence, two radicand bits and one root bit per stage.
    typedef struct packed {
        t_res          r;
        logic [SW-1:0] n;
        logic [LW-1:0] q;
        logic [LW+1:0] rm;
    } t_rt;

    t_rt r_rt [RS+1];
    always_comb begin
        r_rt[0].r = r_c3;
        r_rt[0].n = r_ss3;
        r_rt[0].q = '0;
        r_rt[0].rm = '0;
    end

    for (genvar g = 0; g < RS; g++) begin : g_root
        t_rt w_n;
        always_comb begin
            logic [LW+3:0] t;
            logic [LW+3:0] trial;
            w_n = r_rt[g];
            t = {r_rt[g].rm, r_rt[g].n[SW-1-2*g -: 2]};
            trial = (LW+4)'({r_rt[g].q, 2'b01});
            if (t >= trial) begin
                w_n.rm = (LW+2)'(t - trial);
                w_n.q = {r_rt[g].q[LW-2:0], 1'b1};
            end else begin
                w_n.rm = (LW+2)'(t);
                w_n.q = {r_rt[g].q[LW-2:0], 1'b0};
            end
        end
        t_rt r_st;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st.r.v <= 1'b0;
            end else if (w_adv) begin
                r_st.r.v <= w_n.r.v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st.r.func <= w_n.r.func;
                r_st.r.x <= w_n.r.x; r_st.r.y <= w_n.r.y; r_st.r.z <= w_n.r.z;
                r_st.r.s <= w_n.r.s; r_st.r.eq <= w_n.r.eq; r_st.r.ov <= w_n.r.ov;
                r_st.r.ax <= w_n.r.ax; r_st.r.ay <= w_n.r.ay; r_st.r.az <= w_n.r.az;
                r_st.n <= w_n.n;
                r_st.q <= w_n.q;
                r_st.rm <= w_n.rm;
            end
        end
        assign r_rt[g+1] = r_st;
    end

    // Division pipeline: restoring, one quotient bit per stage for all three lanes.
    typedef struct packed {
        t_res          r;
        logic [LW-1:0] d;
        logic [NW-1:0] nx, ny, nz;
        logic [LW:0]   rx, ry, rz;
        logic [QW-1:0] qx, qy, qz;
    } t_dv;

    function automatic logic [NW-1:0] magn(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return {m, {FB{1'b0}}};
    endfunction

    t_dv r_dv [DS+1];
    always_comb begin
        r_dv[0] = '0;
        r_dv[0].r = r_rt[RS].r;
        r_dv[0].d = r_rt[RS].q;
        r_dv[0].nx = magn(r_rt[RS].r.ax);
        r_dv[0].ny = magn(r_rt[RS].r.ay);
        r_dv[0].nz = magn(r_rt[RS].r.az);
        if (r_rt[RS].r.func == v3a_pkg::OP_LEN) begin
            r_dv[0].r.s = (|r_rt[RS].q[LW-1:CW-1]) ? {1'b0, {(CW-1){1'b1}}}
                                                    : r_rt[RS].q[CW-1:0];
            r_dv[0].r.ov = |r_rt[RS].q[LW-1:CW-1];
        end
    end

    function automatic void dstep(input logic [LW:0] ri, input logic b,
                                  input logic [LW-1:0] d,
                                  output logic [LW:0] ro, output logic qb);
        logic [LW+1:0] t;
        t = {ri, b};
        if (t >= (LW+2)'(d) && d != '0) begin
            ro = (LW+1)'(t - (LW+2)'(d));
            qb = 1'b1;
        end else begin
            ro = (LW+1)'(t);
            qb = 1'b0;
        end
    endfunction

    for (genvar g = 0; g < DS; g++) begin : g_div
        t_dv w_n;
        always_comb begin
            logic bx, by, bz;
            w_n = r_dv[g];
            dstep(r_dv[g].rx, r_dv[g].nx[NW-1-g], r_dv[g].d, w_n.rx, bx);
            dstep(r_dv[g].ry, r_dv[g].ny[NW-1-g], r_dv[g].d, w_n.ry, by);
            dstep(r_dv[g].rz, r_dv[g].nz[NW-1-g], r_dv[g].d, w_n.rz, bz);
            w_n.qx = {r_dv[g].qx[QW-2:0], bx};
            w_n.qy = {r_dv[g].qy[QW-2:0], by};
            w_n.qz = {r_dv[g].qz[QW-2:0], bz};
        end
        t_dv r_st;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st.r.v <= 1'b0;
            end else if (w_adv) begin
                r_st.r.v <= w_n.r.v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st.r.func <= w_n.r.func;
                r_st.r.x <= w_n.r.x; r_st.r.y <= w_n.r.y; r_st.r.z <= w_n.r.z;
                r_st.r.s <= w_n.r.s; r_st.r.eq <= w_n.r.eq; r_st.r.ov <= w_n.r.ov;
                r_st.r.ax <= w_n.r.ax; r_st.r.ay <= w_n.r.ay; r_st.r.az <= w_n.r.az;
                r_st.d <= w_n.d;
                r_st.nx <= w_n.nx; r_st.ny <= w_n.ny; r_st.nz <= w_n.nz;
                r_st.rx <= w_n.rx; r_st.ry <= w_n.ry; r_st.rz <= w_n.rz;
                r_st.qx <= w_n.qx; r_st.qy <= w_n.qy; r_st.qz <= w_n.qz;
            end
        end
        assign r_dv[g+1] = r_st;
    end

    // Final stage: sign, saturate quotients, output register.
    function automatic logic signed [CW-1:0] qsat(input logic [QW-1:0] q, input logic neg,
                                                  output logic ov);
        t_w v;
        v = neg ? -t_w'({1'b0, q}) : t_w'({1'b0, q});
        return sat(v, ov);
    endfunction

    t_res w_f;
    logic n_zl;
    always_comb begin
        logic o0, o1, o2;
        w_f = r_dv[DS].r;
        n_zl = 1'b0;
        o0 = 1'b0; o1 = 1'b0; o2 = 1'b0;
        if (r_dv[DS].r.func == v3a_pkg::OP_NORM) begin
            if (r_dv[DS].d == '0) begin
                n_zl = 1'b1;
            end else begin
                w_f.x = qsat(r_dv[DS].qx, r_dv[DS].r.ax[CW-1], o0);
                w_f.y = qsat(r_dv[DS].qy, r_dv[DS].r.ay[CW-1], o1);
                w_f.z = qsat(r_dv[DS].qz, r_dv[DS].r.az[CW-1], o2);
                w_f.ov = o0 | o1 | o2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_f.v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_rx <= w_f.x; o_ry <= w_f.y; o_rz <= w_f.z; o_rs <= w_f.s;
            o_eq <= w_f.eq; o_ov <= w_f.ov; o_zl <= n_zl;
        end
    end

    logic w_unused;
    assign w_unused = ^{i_cls.root, i_cls.div, NS[0]};
endmodule
`default_nettype wire

### src/vector3_alu.sv
// Top level of the three-component vector ALU: front queue, pipelined back part, result queue.
//
// Usage: push an item (func, a, b, factor) while full is low; one item per cycle
// is taken. Results come out in order on the result queue; empty low means
// the oldest result is on o_r_* ports, and pop takes it.
// Path from the accepting edge until the result is on the ports: the front
// queue, three front stages of the back part, one stage per root bit, one stage
// per quotient bit of the normalize divider, the output register and the result
// queue. Throughput is one item per cycle for every opcode while the result
// queue has room.
// A stalled receiver fills the four-entry result queue; the whole back pipeline
// then holds until a pop frees a slot, the front queue fills and full rises.
// No item is lost or repeated.
// Reset (i_rst_n low, synchronous) empties both queues and clears the pipeline
// valid bits. Payload registers keep stale data that is never shown.
`default_nettype none
module vector3_alu #(
    parameter int COMP_WIDTH = v3a_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [v3a_pkg::FUNC_W-1:0]   i_func,
    input  wire logic signed [COMP_WIDTH-1:0] i_a_x, i_a_y, i_a_z,
    input  wire logic signed [COMP_WIDTH-1:0] i_b_x, i_b_y, i_b_z,
    input  wire logic signed [COMP_WIDTH-1:0] i_factor,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [COMP_WIDTH-1:0]      o_r_x, o_r_y, o_r_z, o_r_scalar,
    output logic                              o_equal,
    output logic                              o_overflow,
    output logic                              o_zero_length
);
    localparam int CW = COMP_WIDTH;
    localparam int IW = v3a_pkg::FUNC_W + 3 + 7*CW;
    localparam int OW = 4*CW + 3;

    logic [IW-1:0] w_in, w_q;
    logic          w_qe, w_bk_rdy, w_bk_v, w_of;
    v3a_pkg::t_class w_cls;
    logic [v3a_pkg::FUNC_W-1:0] w_fn;
    logic signed [CW-1:0] w_ax, w_ay, w_az, w_bx, w_by, w_bz, w_f;
    logic signed [CW-1:0] w_rx, w_ry, w_rz, w_rs;
    logic w_eq, w_ov, w_zl;
    logic [OW-1:0] w_out;

    // Front: classify on entry and queue.
    assign w_in = {i_func, v3a_pkg::classify(v3a_pkg::t_func'(i_func)),
                   i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_factor};

    v3a_fifo #(.WIDTH(IW), .DEPTH(4)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data(w_in), .o_full(full),
        .i_pop(w_bk_rdy), .o_data(w_q), .o_empty(w_qe)
    );

    assign {w_fn, w_cls, w_ax, w_ay, w_az, w_bx, w_by, w_bz, w_f} = w_q;

    v3a_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(!w_qe), .o_ready(w_bk_rdy),
        .i_func(v3a_pkg::t_func'(w_fn)), .i_cls(w_cls),
        .i_ax(w_ax), .i_ay(w_ay), .i_az(w_az),
        .i_bx(w_bx), .i_by(w_by), .i_bz(w_bz), .i_f(w_f),
        .o_valid(w_bk_v), .i_ready(!w_of),
        .o_rx(w_rx), .o_ry(w_ry), .o_rz(w_rz), .o_rs(w_rs),
        .o_eq(w_eq), .o_ov(w_ov), .o_zl(w_zl)
    );

    // Result queue; back stalls only while it is full.
    v3a_fifo #(.WIDTH(OW), .DEPTH(4)) u_out (
        .i_clk, .i_rst_n,
        .i_push(w_bk_v), .i_data({w_rx, w_ry, w_rz, w_rs, w_eq, w_ov, w_zl}),
        .o_full(w_of),
        .i_pop(pop), .o_data(w_out), .o_empty(empty)
    );

    assign {o_r_x, o_r_y, o_r_z, o_r_scalar, o_equal, o_overflow, o_zero_length} = w_out;
endmodule
`default_nettype wire

### dv/vector3_alu_chk.sv
// Checker for the vector ALU: watches both queues, predicts each result and compares.
`timescale 1ns / 100ps
module vector3_alu_chk (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic [2:0]              i_func,
    input  logic signed [31:0]      i_a_x, i_a_y, i_a_z,
    input  logic signed [31:0]      i_b_x, i_b_y, i_b_z,
    input  logic signed [31:0]      i_factor,
    input  logic                    empty,
    input  logic                    pop,
    input  logic signed [31:0]      o_r_x, o_r_y, o_r_z, o_r_scalar,
    input  logic                    o_equal,
    input  logic                    o_overflow,
    input  logic                    o_zero_length,
    output int                      o_errors,
    output int                      o_pending
);
    typedef struct packed {
        logic [31:0] x, y, z, s;
        logic        eq, ov, zl;
    } t_vres;

    t_vres vres_q[$];
    int    errors = 0;
    int    pend = 0;

    assign o_errors  = errors;
    assign o_pending = pend;

    localparam logic signed [127:0] CMAX = 128'sh7fffffff;
    localparam logic signed [127:0] CMIN = -128'sh80000000;

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ov);
        if (v > CMAX) begin
            ov = 1'b1;
            return CMAX[31:0];
        end
        if (v < CMIN) begin
            ov = 1'b1;
            return CMIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    function automatic t_vres compute_vres(input logic [2:0] fn,
                                           input logic signed [31:0] a[3],
                                           input logic signed [31:0] b[3],
                                           input logic signed [31:0] f);
        t_vres                r;
        logic signed [127:0]  p, s;
        logic [127:0]         ss, num, q, m;
        logic [63:0]          len;
        logic [31:0]          v[3];
        logic                 ov;
        int                   j, k;
        r  = '0;
        ov = 1'b0;
        v  = '{0, 0, 0};
        case (v3a_pkg::t_func'(fn))
            v3a_pkg::OP_CROSS: for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                p = 128'(a[j]) * 128'(b[k]) - 128'(b[j]) * 128'(a[k]);
                v[i] = clamp(p >>> 16, ov);
            end
            v3a_pkg::OP_SUM:
                for (int i = 0; i < 3; i++) v[i] = clamp(128'(a[i]) + 128'(b[i]), ov);
            v3a_pkg::OP_DIFF:
                for (int i = 0; i < 3; i++) v[i] = clamp(128'(a[i]) - 128'(b[i]), ov);
            v3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++)
                v[i] = clamp((128'(a[i]) * 128'(f)) >>> 16, ov);
            v3a_pkg::OP_NORM, v3a_pkg::OP_LEN: begin
                ss = 0;
                for (int i = 0; i < 3; i++) ss += 128'(a[i]) * 128'(a[i]);
                len = root_floor(ss);
                if (v3a_pkg::t_func'(fn) == v3a_pkg::OP_LEN) begin
                    r.s = clamp($signed({64'd0, len}), ov);
                end else if (len == 0) begin
                    r.zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        m = a[i] < 0 ? -128'(a[i]) : 128'(a[i]);
                        num = m << 16;
                        q = num / {64'd0, len};
                        v[i] = clamp(a[i] < 0 ? -$signed(q) : $signed(q), ov);
                    end
                end
            end
            v3a_pkg::OP_DOT: begin
                s = 0;
                for (int i = 0; i < 3; i++) s += 128'(a[i]) * 128'(b[i]);
                r.s = clamp(s >>> 16, ov);
            end
            default: r.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
        endcase
        r.x  = v[0];
        r.y  = v[1];
        r.z  = v[2];
        r.ov = ov;
        return r;
    endfunction

    t_vres got, want;

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            vres_q.push_back(compute_vres(i_func, '{i_a_x, i_a_y, i_a_z},
                                          '{i_b_x, i_b_y, i_b_z}, i_factor));
        if (i_rst_n && pop && !empty) begin
            got = '{o_r_x, o_r_y, o_r_z, o_r_scalar, o_equal, o_overflow, o_zero_length};
            if (vres_q.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h", $time, got);
                errors++;
            end else begin
                want = vres_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch x/y/z/s/eq/ov/zl expected %h actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        end
        pend = vres_q.size();
    end
endmodule

### dv/tb_vector3_alu.sv
// Testbench top for the vector ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_vector3_alu;
    logic               i_clk = 0, i_rst_n = 0, push = 0, pop = 0;
    logic               full, empty;
    logic [2:0]         i_func = '0;
    logic signed [31:0] i_a_x = 0, i_a_y = 0, i_a_z = 0;
    logic signed [31:0] i_b_x = 0, i_b_y = 0, i_b_z = 0, i_factor = 0;
    logic signed [31:0] o_r_x, o_r_y, o_r_z, o_r_scalar;
    logic               o_equal, o_overflow, o_zero_length;
    int                 errors, pending;
    int                 cycles = 0;
    int                 sent = 0;
    bit                 calm = 0;

    always #10 i_clk = ~i_clk;

    vector3_alu DUT (.*);
    vector3_alu_chk u_chk (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk)
        pop <= calm ? 1'b1 : ($urandom_range(99) >= 27);

    function automatic logic [31:0] pick_comp();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(1) ? 32'h10000 : 32'hffff0000;
            4, 5: return $signed($urandom_range(65535)) - 32768 << $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [2:0] fn, input logic [31:0] ax, ay, az,
                        input logic [31:0] bx, by, bz, fc);
        push     <= 1'b1;
        i_func   <= fn;
        i_a_x    <= ax;
        i_a_y    <= ay;
        i_a_z    <= az;
        i_b_x    <= bx;
        i_b_y    <= by;
        i_b_z    <= bz;
        i_factor <= fc;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
        while (!calm && $urandom_range(99) < 27) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    logic [31:0] v[7];

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int f = 0; f < 8; f++) begin
            send(3'(f), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
            send(3'(f), 32'h10000, 32'h20000, 32'hfffd0000,
                 32'h10000, 32'h20000, 32'hfffd0000, 32'h18000);
        end
        send(v3a_pkg::OP_NORM, 0, 0, 0, 1, 2, 3, 4);
        send(v3a_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
        send(v3a_pkg::OP_LEN, 0, 0, 0, 0, 0, 0, 0);
        send(v3a_pkg::OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        send(v3a_pkg::OP_CMP, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff, 32'hfffffffe, 0);
        for (int n = 0; n < 1200; n++) begin
            calm = (n >= 500 && n < 650);
            foreach (v[i]) v[i] = pick_comp();
            if ($urandom_range(3) == 0) begin
                v[3] = v[0];
                v[4] = v[1];
                v[5] = $urandom_range(1) ? v[2] : pick_comp();
            end
            send(3'($urandom_range(7)), v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
        end
        push <= 1'b0;
        calm = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
